// ===== rtl/core/cpfm_pkg.sv =====
// Shared constants, codes and state type of the copy-on-write page frame manager.
`timescale 1ns / 1ps
`default_nettype none
package cpfm_pkg;
  localparam int NUM_FRAMES_DEF    = 64;
  localparam int PTES_PER_DIR_DEF  = 16;
  localparam int PROCESS_SLOTS_DEF = 4;

  localparam int ACTION_W    = 2;
  localparam int VPN_W       = 8;
  localparam int PID_W       = 8;
  localparam int FRAME_OUT_W = 6;
  localparam int STATUS_W    = 2;
  localparam int CNT_W       = 3;
  localparam logic [CNT_W-1:0] CNT_MAX = 3'd7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_FAULT  = 2'd2,
    ACT_SWITCH = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NOFRAME = 2'd1,
    ST_REJECT  = 2'd2,
    ST_NOSLOT  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PTE_RD,
    S_PTE_DAT,
    S_CNT_DAT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FLT_DEC,
    S_SWITCH,
    S_FK_RD,
    S_FK_PTE,
    S_FK_CNT,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/cpfm_if.sv =====
// Request and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface cpfm_in_if;
  logic                          valid;
  logic                          ready;
  logic [cpfm_pkg::ACTION_W-1:0] action;
  logic [cpfm_pkg::VPN_W-1:0]    vpn;
  logic                          is_write;
  logic [cpfm_pkg::PID_W-1:0]    pid;
  modport source (output valid, action, vpn, is_write, pid, input ready);
  modport sink (input valid, action, vpn, is_write, pid, output ready);
endinterface

interface cpfm_out_if;
  logic                             valid;
  logic                             ready;
  logic                             ok;
  logic [cpfm_pkg::FRAME_OUT_W-1:0] frame;
  logic [cpfm_pkg::STATUS_W-1:0]    status;
  modport source (output valid, ok, frame, status, input ready);
  modport sink (input valid, ok, frame, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cow_page_frame_manager.sv =====
// Top level of the copy-on-write page frame manager.
// Allocate scans the frame counts for a free frame; a fault on a copy-on-write page whose
// frame is shared scans likewise for a copy; a fork walks every page table entry.
// One word in flight; the next is taken once the result sits in the output register.
// The sequence is set by the single write port of the page table RAM and the count RAM.
// Reset (synchronous, rst_n low) starts a clearing pass over the page table RAM and the
// count RAM, during which no word is accepted.
`timescale 1ns / 1ps
`default_nettype none
module cow_page_frame_manager #(
  parameter int NUM_FRAMES    = cpfm_pkg::NUM_FRAMES_DEF,
  parameter int PTES_PER_DIR  = cpfm_pkg::PTES_PER_DIR_DEF,
  parameter int PROCESS_SLOTS = cpfm_pkg::PROCESS_SLOTS_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  cpfm_in_if.sink     in_chan,
  cpfm_out_if.source  out_chan
);
  localparam int PAGES = PTES_PER_DIR * PTES_PER_DIR;
  localparam int TOTAL = PAGES * PROCESS_SLOTS;
  localparam int AW    = $clog2(TOTAL);
  localparam int PW    = $clog2(PAGES);
  localparam int FW    = $clog2(NUM_FRAMES);
  localparam int SW    = $clog2(PROCESS_SLOTS);
  localparam int PTE_W = FW + 3;
  localparam int CW    = cpfm_pkg::CNT_W;
  localparam int FO_W  = cpfm_pkg::FRAME_OUT_W;
  localparam int PIDW  = cpfm_pkg::PID_W;
  localparam int VPN_N = 2 ** cpfm_pkg::VPN_W;
  localparam int CLR_N = (TOTAL > NUM_FRAMES) ? TOTAL : NUM_FRAMES;
  localparam int CLW   = $clog2(CLR_N + 1);
  localparam logic [AW-1:0] PAGES_A = AW'(PAGES);

  logic [PW-1:0] vpn_tbl [VPN_N];
  for (genvar g = 0; g < VPN_N; g++) begin : g_vpn
    assign vpn_tbl[g] = PW'(g % PAGES);
  end

  cpfm_pkg::state_t state_r, state_nxt;
  logic [CLW-1:0]   clr_r, clr_nxt;
  logic [1:0]       act_r, act_nxt;
  logic [AW-1:0]    e_r, e_nxt;
  logic             wr_r, wr_nxt;
  logic [PIDW-1:0]  pid_r, pid_nxt;
  logic [PTE_W-1:0] pte_r, pte_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [FW-1:0]    scan_r, scan_nxt;
  logic [PW-1:0]    idx_r, idx_nxt;
  logic [SW-1:0]    child_r, child_nxt;
  logic [SW-1:0]    cur_r, cur_nxt;
  logic [PROCESS_SLOTS-1:0] used_r, used_nxt;
  logic [PIDW-1:0]  pidtab_r [PROCESS_SLOTS];
  logic [PIDW-1:0]  pidtab_nxt [PROCESS_SLOTS];
  logic             res_ok_r, res_ok_nxt;
  logic [FO_W-1:0]  res_frame_r, res_frame_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [FO_W-1:0]  out_frame_r, out_frame_nxt;
  logic [1:0]       out_status_r, out_status_nxt;

  logic             pte_we, cnt_we;
  logic [AW-1:0]    pte_waddr, pte_raddr;
  logic [PTE_W-1:0] pte_wdata, pte_rdata;
  logic [FW-1:0]    cnt_waddr, cnt_raddr;
  logic [CW-1:0]    cnt_wdata, cnt_rdata;

  cpfm_ram #(.WIDTH(PTE_W), .DEPTH(TOTAL)) u_pte_ram (
    .clk(clk), .we(pte_we), .waddr(pte_waddr), .wdata(pte_wdata),
    .raddr(pte_raddr), .rdata(pte_rdata)
  );

  cpfm_ram #(.WIDTH(CW), .DEPTH(NUM_FRAMES)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  logic          in_fire, out_load, match_hit, free_hit, fk_last, copy_hit;
  logic [SW-1:0] match_s, free_s;
  logic          rd_v, rd_w, rd_p;
  logic [FW-1:0] rd_f;
  logic [AW-1:0] pb_addr, cb_addr;

  assign in_chan.ready   = (state_r == cpfm_pkg::S_IDLE);
  assign in_fire         = in_chan.valid && in_chan.ready;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.ok     = out_ok_r;
  assign out_chan.frame  = out_frame_r;
  assign out_chan.status = out_status_r;
  assign out_load        = (state_r == cpfm_pkg::S_DONE) && (!out_valid_r || out_chan.ready);

  assign rd_v    = pte_rdata[FW+2];
  assign rd_w    = pte_rdata[FW+1];
  assign rd_p    = pte_rdata[FW];
  assign rd_f    = pte_rdata[FW-1:0];
  assign pb_addr = AW'(cur_r) * PAGES_A + AW'(idx_r);
  assign cb_addr = AW'(child_r) * PAGES_A + AW'(idx_r);
  assign fk_last = (idx_r == PW'(PAGES - 1));
  assign copy_hit = (cnt_rdata > CW'(1));

  always_comb begin
    match_hit = 1'b0;
    match_s   = '0;
    free_hit  = 1'b0;
    free_s    = '0;
    for (int s = 0; s < PROCESS_SLOTS; s++) begin
      if (!match_hit && (SW'(s) != cur_r) && used_r[s] && (pidtab_r[s] == pid_r)) begin
        match_hit = 1'b1;
        match_s   = SW'(s);
      end
      if (!free_hit && !used_r[s]) begin
        free_hit = 1'b1;
        free_s   = SW'(s);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cpfm_pkg::S_CLEAR: begin
        if (clr_r == CLW'(CLR_N - 1)) state_nxt = cpfm_pkg::S_IDLE;
      end
      cpfm_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (in_chan.action)
            cpfm_pkg::ACT_ALLOC:  state_nxt = cpfm_pkg::S_SCAN_RD;
            cpfm_pkg::ACT_SWITCH: state_nxt = cpfm_pkg::S_SWITCH;
            default:              state_nxt = cpfm_pkg::S_PTE_RD;
          endcase
        end
      end
      cpfm_pkg::S_PTE_RD: state_nxt = cpfm_pkg::S_PTE_DAT;
      cpfm_pkg::S_PTE_DAT: begin
        if (!rd_v) state_nxt = cpfm_pkg::S_DONE;
        else if (act_r == cpfm_pkg::ACT_FREE) state_nxt = cpfm_pkg::S_CNT_DAT;
        else if (rd_p) state_nxt = cpfm_pkg::S_CNT_DAT;
        else state_nxt = cpfm_pkg::S_DONE;
      end
      cpfm_pkg::S_CNT_DAT: begin
        if (act_r == cpfm_pkg::ACT_FAULT && copy_hit) state_nxt = cpfm_pkg::S_SCAN_RD;
        else state_nxt = cpfm_pkg::S_DONE;
      end
      cpfm_pkg::S_SCAN_RD: state_nxt = cpfm_pkg::S_SCAN_CHK;
      cpfm_pkg::S_SCAN_CHK: begin
        if (cnt_rdata == '0) begin
          state_nxt = (act_r == cpfm_pkg::ACT_FAULT) ? cpfm_pkg::S_FLT_DEC : cpfm_pkg::S_DONE;
        end else if (scan_r == FW'(NUM_FRAMES - 1)) begin
          state_nxt = cpfm_pkg::S_DONE;
        end else begin
          state_nxt = cpfm_pkg::S_SCAN_RD;
        end
      end
      cpfm_pkg::S_FLT_DEC: state_nxt = cpfm_pkg::S_DONE;
      cpfm_pkg::S_SWITCH: begin
        if (!match_hit && free_hit) state_nxt = cpfm_pkg::S_FK_RD;
        else state_nxt = cpfm_pkg::S_DONE;
      end
      cpfm_pkg::S_FK_RD: state_nxt = cpfm_pkg::S_FK_PTE;
      cpfm_pkg::S_FK_PTE: begin
        if (rd_v) state_nxt = cpfm_pkg::S_FK_CNT;
        else if (fk_last) state_nxt = cpfm_pkg::S_DONE;
        else state_nxt = cpfm_pkg::S_FK_RD;
      end
      cpfm_pkg::S_FK_CNT: begin
        state_nxt = fk_last ? cpfm_pkg::S_DONE : cpfm_pkg::S_FK_RD;
      end
      cpfm_pkg::S_DONE: begin
        if (out_load) state_nxt = cpfm_pkg::S_IDLE;
      end
      default: state_nxt = cpfm_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    clr_nxt        = clr_r;
    act_nxt        = act_r;
    e_nxt          = e_r;
    wr_nxt         = wr_r;
    pid_nxt        = pid_r;
    pte_nxt        = pte_r;
    cnt_nxt        = cnt_r;
    scan_nxt       = scan_r;
    idx_nxt        = idx_r;
    child_nxt      = child_r;
    cur_nxt        = cur_r;
    used_nxt       = used_r;
    pidtab_nxt     = pidtab_r;
    res_ok_nxt     = res_ok_r;
    res_frame_nxt  = res_frame_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_ok_nxt     = out_ok_r;
    out_frame_nxt  = out_frame_r;
    out_status_nxt = out_status_r;
    pte_we         = 1'b0;
    pte_waddr      = e_r;
    pte_wdata      = '0;
    pte_raddr      = e_r;
    cnt_we         = 1'b0;
    cnt_waddr      = pte_r[FW-1:0];
    cnt_wdata      = '0;
    cnt_raddr      = scan_r;
    unique case (state_r)
      cpfm_pkg::S_CLEAR: begin
        clr_nxt   = clr_r + CLW'(1);
        pte_we    = (clr_r < CLW'(TOTAL));
        pte_waddr = clr_r[AW-1:0];
        cnt_we    = (clr_r < CLW'(NUM_FRAMES));
        cnt_waddr = clr_r[FW-1:0];
      end
      cpfm_pkg::S_IDLE: begin
        if (in_fire) begin
          act_nxt        = in_chan.action;
          e_nxt          = AW'(cur_r) * PAGES_A + AW'(vpn_tbl[in_chan.vpn]);
          wr_nxt         = in_chan.is_write;
          pid_nxt        = in_chan.pid;
          scan_nxt       = '0;
          res_ok_nxt     = 1'b1;
          res_frame_nxt  = '0;
          res_status_nxt = cpfm_pkg::ST_DONE;
        end
      end
      cpfm_pkg::S_PTE_DAT: begin
        pte_nxt   = pte_rdata;
        cnt_raddr = rd_f;
        if (!rd_v || (act_r == cpfm_pkg::ACT_FAULT && wr_r && !rd_w && !rd_p)) begin
          res_ok_nxt     = 1'b0;
          res_status_nxt = cpfm_pkg::ST_REJECT;
        end
      end
      cpfm_pkg::S_CNT_DAT: begin
        cnt_nxt = cnt_rdata;
        if (act_r == cpfm_pkg::ACT_FREE) begin
          cnt_we    = 1'b1;
          cnt_wdata = (cnt_rdata != '0) ? cnt_rdata - CW'(1) : cnt_rdata;
          pte_we    = 1'b1;
        end else if (!copy_hit) begin
          pte_we    = 1'b1;
          pte_wdata = {3'b110, pte_r[FW-1:0]};
        end
      end
      cpfm_pkg::S_SCAN_CHK: begin
        if (cnt_rdata == '0) begin
          cnt_we        = 1'b1;
          cnt_waddr     = scan_r;
          cnt_wdata     = CW'(1);
          pte_we        = 1'b1;
          pte_wdata     = {1'b1, (act_r == cpfm_pkg::ACT_FAULT) || wr_r, 1'b0, scan_r};
          res_frame_nxt = FO_W'(scan_r);
        end else if (scan_r == FW'(NUM_FRAMES - 1)) begin
          res_ok_nxt     = 1'b0;
          res_status_nxt = cpfm_pkg::ST_NOFRAME;
        end else begin
          scan_nxt = scan_r + FW'(1);
        end
      end
      cpfm_pkg::S_FLT_DEC: begin
        cnt_we    = 1'b1;
        cnt_wdata = cnt_r - CW'(1);
      end
      cpfm_pkg::S_SWITCH: begin
        idx_nxt   = '0;
        child_nxt = free_s;
        if (match_hit) begin
          cur_nxt = match_s;
        end else if (!free_hit) begin
          res_ok_nxt     = 1'b0;
          res_status_nxt = cpfm_pkg::ST_NOSLOT;
        end
      end
      cpfm_pkg::S_FK_RD: begin
        pte_raddr = pb_addr;
      end
      cpfm_pkg::S_FK_PTE: begin
        pte_nxt   = pte_rdata;
        cnt_raddr = rd_f;
        pte_we    = 1'b1;
        pte_waddr = cb_addr;
        pte_wdata = rd_v ? {2'b10, rd_w || rd_p, rd_f} : '0;
      end
      cpfm_pkg::S_FK_CNT: begin
        cnt_we    = 1'b1;
        cnt_wdata = (cnt_rdata < cpfm_pkg::CNT_MAX) ? cnt_rdata + CW'(1) : cnt_rdata;
        pte_we    = pte_r[FW+1] || pte_r[FW];
        pte_waddr = pb_addr;
        pte_wdata = {3'b101, pte_r[FW-1:0]};
      end
      cpfm_pkg::S_DONE: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_ok_nxt     = res_ok_r;
          out_frame_nxt  = res_frame_r;
          out_status_nxt = res_status_r;
        end
      end
      default: begin
      end
    endcase
    if ((state_r == cpfm_pkg::S_FK_CNT || (state_r == cpfm_pkg::S_FK_PTE && !rd_v))) begin
      if (fk_last) begin
        used_nxt[child_r]   = 1'b1;
        pidtab_nxt[child_r] = pid_r;
        cur_nxt             = child_r;
      end else begin
        idx_nxt = idx_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpfm_pkg::S_CLEAR;
      clr_r       <= '0;
      cur_r       <= '0;
      used_r      <= {{(PROCESS_SLOTS-1){1'b0}}, 1'b1};
      out_valid_r <= 1'b0;
      for (int s = 0; s < PROCESS_SLOTS; s++) pidtab_r[s] <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cur_r       <= cur_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      pidtab_r    <= pidtab_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    e_r          <= e_nxt;
    wr_r         <= wr_nxt;
    pid_r        <= pid_nxt;
    pte_r        <= pte_nxt;
    cnt_r        <= cnt_nxt;
    scan_r       <= scan_nxt;
    idx_r        <= idx_nxt;
    child_r      <= child_nxt;
    res_ok_r     <= res_ok_nxt;
    res_frame_r  <= res_frame_nxt;
    res_status_r <= res_status_nxt;
    out_ok_r     <= out_ok_nxt;
    out_frame_r  <= out_frame_nxt;
    out_status_r <= out_status_nxt;
  end

  a_cur_used: assert property (@(posedge clk) disable iff (!rst_n) used_r[cur_r])
    else $error("current slot not in use");
  a_fail_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok_r |-> out_frame_r == '0)
    else $error("failed result carries a frame");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != cpfm_pkg::S_IDLE)
    else $error("word accepted without work");
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cpfm_pkg::S_CLEAR |-> !out_valid_r && !in_chan.ready)
    else $error("activity during clearing pass");
endmodule
`default_nettype wire

// ===== rtl/core/cpfm_ram.sv =====
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module cpfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== test/cow_page_frame_manager_tb.sv =====
// Testbench for the copy-on-write page frame manager: directed and random actions checked
// against a behavioral model of the page tables, frame counts and process slots.
`timescale 1ns / 1ps
`default_nettype none
module cow_page_frame_manager_tb;
  localparam int FRAMES = 64;
  localparam int PAGES = 256;
  localparam int SLOTS = 4;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic                  ok;
    logic [5:0]            frame;
    cpfm_pkg::status_t     status;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  cpfm_in_if in_chan ();
  cpfm_out_if out_chan ();

  cow_page_frame_manager u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source)
  );

  logic       pg_valid [SLOTS*PAGES];
  logic       pg_writable [SLOTS*PAGES];
  logic       pg_private [SLOTS*PAGES];
  logic [5:0] pg_frame [SLOTS*PAGES];
  logic [2:0] frame_refs [FRAMES];
  logic       slot_busy [SLOTS];
  logic [7:0] slot_owner [SLOTS];
  int         cur_slot;

  outcome_t expected_outcomes[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  calm = 0;
  bit  timed_out = 0;

  function automatic int first_free_frame();
    for (int f = 0; f < FRAMES; f++)
      if (frame_refs[f] == 3'd0) return f;
    return -1;
  endfunction

  function automatic void ref_inc(logic [5:0] f);
    if (frame_refs[f] < 3'd7) frame_refs[f]++;
  endfunction

  function automatic void ref_dec(logic [5:0] f);
    if (frame_refs[f] > 3'd0) frame_refs[f]--;
  endfunction

  function automatic outcome_t apply_action(cpfm_pkg::action_t act, logic [7:0] vpn,
                                            logic wr, logic [7:0] pid);
    outcome_t r;
    int e, f, p, c;
    logic [5:0] old;
    r = '{ok: 1'b1, frame: 6'd0, status: cpfm_pkg::ST_DONE};
    e = cur_slot * PAGES + int'(vpn);
    case (act)
      cpfm_pkg::ACT_ALLOC: begin
        f = first_free_frame();
        if (f < 0) begin
          r = '{ok: 1'b0, frame: 6'd0, status: cpfm_pkg::ST_NOFRAME};
        end else begin
          pg_valid[e] = 1; pg_writable[e] = wr; pg_private[e] = 0; pg_frame[e] = 6'(f);
          ref_inc(6'(f));
          r.frame = 6'(f);
        end
      end
      cpfm_pkg::ACT_FREE: begin
        if (!pg_valid[e]) begin
          r = '{ok: 1'b0, frame: 6'd0, status: cpfm_pkg::ST_REJECT};
        end else begin
          ref_dec(pg_frame[e]);
          pg_valid[e] = 0; pg_writable[e] = 0; pg_private[e] = 0; pg_frame[e] = 0;
        end
      end
      cpfm_pkg::ACT_FAULT: begin
        old = pg_frame[e];
        if (!pg_valid[e] || (wr && !pg_writable[e] && !pg_private[e])) begin
          r = '{ok: 1'b0, frame: 6'd0, status: cpfm_pkg::ST_REJECT};
        end else if (pg_private[e] && frame_refs[old] > 3'd1) begin
          f = first_free_frame();
          if (f < 0) begin
            r = '{ok: 1'b0, frame: 6'd0, status: cpfm_pkg::ST_NOFRAME};
          end else begin
            ref_dec(old);
            pg_frame[e] = 6'(f); pg_writable[e] = 1; pg_private[e] = 0;
            ref_inc(6'(f));
            r.frame = 6'(f);
          end
        end else if (pg_private[e]) begin
          pg_writable[e] = 1; pg_private[e] = 0;
        end
      end
      default: begin
        for (int s = 0; s < SLOTS; s++)
          if (s != cur_slot && slot_busy[s] && slot_owner[s] == pid) begin
            cur_slot = s;
            return r;
          end
        for (int s = 0; s < SLOTS; s++)
          if (!slot_busy[s]) begin
            for (int i = 0; i < PAGES; i++) begin
              p = cur_slot * PAGES + i;
              c = s * PAGES + i;
              pg_valid[c] = 0; pg_writable[c] = 0; pg_private[c] = 0; pg_frame[c] = 0;
              if (pg_valid[p]) begin
                if (pg_writable[p] || pg_private[p]) begin
                  pg_writable[p] = 0; pg_private[p] = 1; pg_private[c] = 1;
                end
                pg_valid[c] = 1;
                pg_frame[c] = pg_frame[p];
                ref_inc(pg_frame[p]);
              end
            end
            slot_busy[s] = 1; slot_owner[s] = pid; cur_slot = s;
            return r;
          end
        r = '{ok: 1'b0, frame: 6'd0, status: cpfm_pkg::ST_NOSLOT};
      end
    endcase
    return r;
  endfunction

  task automatic send_word(cpfm_pkg::action_t act, logic [7:0] vpn, logic wr,
                           logic [7:0] pid);
    while (!calm && $urandom_range(99) < 24) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.action <= act;
    in_chan.vpn <= vpn;
    in_chan.is_write <= wr;
    in_chan.pid <= pid;
    do @(posedge clk); while (!in_chan.ready);
    expected_outcomes.push_back(apply_action(act, vpn, wr, pid));
    @(negedge clk);
  endtask

  always @(negedge clk)
    out_chan.ready <= calm || ($urandom_range(99) >= 24);

  always @(posedge clk) begin
    if (out_chan.valid && out_chan.ready) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result ok=%0d frame=%0d status=%0d", $time,
                 out_chan.ok, out_chan.frame, out_chan.status);
        errors++;
      end else begin
        outcome_t want;
        want = expected_outcomes.pop_front();
        if (out_chan.ok !== want.ok || out_chan.frame !== want.frame ||
            out_chan.status !== want.status) begin
          $display("%0t: expected ok=%0d frame=%0d status=%0d, got ok=%0d frame=%0d status=%0d",
                   $time, want.ok, want.frame, want.status,
                   out_chan.ok, out_chan.frame, out_chan.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("cow_page_frame_manager_tb NOT OK");
      $finish;
    end
  end

  task automatic test_alloc_free_edges();
    send_word(cpfm_pkg::ACT_FREE, 8'd0, 1'b0, 8'd0);
    send_word(cpfm_pkg::ACT_FAULT, 8'd255, 1'b1, 8'd0);
    send_word(cpfm_pkg::ACT_ALLOC, 8'd0, 1'b1, 8'd0);
    send_word(cpfm_pkg::ACT_ALLOC, 8'd255, 1'b0, 8'hFF);
    send_word(cpfm_pkg::ACT_ALLOC, 8'd0, 1'b0, 8'd0);
    send_word(cpfm_pkg::ACT_FAULT, 8'd255, 1'b1, 8'd0);
    send_word(cpfm_pkg::ACT_FAULT, 8'd255, 1'b0, 8'd0);
    send_word(cpfm_pkg::ACT_FREE, 8'd0, 1'b1, 8'd0);
    send_word(cpfm_pkg::ACT_FREE, 8'd0, 1'b0, 8'd0);
  endtask

  task automatic test_fork_and_cow();
    send_word(cpfm_pkg::ACT_ALLOC, 8'd5, 1'b1, 8'd0);
    send_word(cpfm_pkg::ACT_SWITCH, 8'd0, 1'b0, 8'd7);
    send_word(cpfm_pkg::ACT_FAULT, 8'd5, 1'b1, 8'd0);
    send_word(cpfm_pkg::ACT_FAULT, 8'd255, 1'b1, 8'd0);
    send_word(cpfm_pkg::ACT_SWITCH, 8'd0, 1'b0, 8'd0);
    send_word(cpfm_pkg::ACT_FAULT, 8'd5, 1'b1, 8'd0);
    send_word(cpfm_pkg::ACT_SWITCH, 8'd0, 1'b0, 8'd9);
    send_word(cpfm_pkg::ACT_SWITCH, 8'd0, 1'b0, 8'hAA);
    send_word(cpfm_pkg::ACT_SWITCH, 8'd0, 1'b0, 8'h55);
    send_word(cpfm_pkg::ACT_SWITCH, 8'd0, 1'b0, 8'd0);
  endtask

  task automatic test_frame_exhaustion();
    for (int i = 0; i < 70; i++)
      send_word(cpfm_pkg::ACT_ALLOC, 8'(i), 1'($urandom_range(1)),
                8'($urandom_range(255)));
    send_word(cpfm_pkg::ACT_FAULT, 8'd255, 1'b1, 8'd0);
    for (int i = 0; i < 40; i++)
      send_word(cpfm_pkg::ACT_FREE, 8'(i), 1'b0, 8'd0);
  endtask

  task automatic test_random_actions(int n);
    cpfm_pkg::action_t act;
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3 && i < n / 2);
      case ($urandom_range(15))
        0, 1, 2, 3, 4, 5: act = cpfm_pkg::ACT_ALLOC;
        6, 7, 8, 9:       act = cpfm_pkg::ACT_FREE;
        10, 11, 12, 13, 14: act = cpfm_pkg::ACT_FAULT;
        default:          act = cpfm_pkg::ACT_SWITCH;
      endcase
      send_word(act, ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
                8'($urandom_range(31)), 1'($urandom_range(1)),
                ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
                8'($urandom_range(3)));
    end
    calm = 0;
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.action = cpfm_pkg::ACT_ALLOC;
    in_chan.vpn = '0;
    in_chan.is_write = 1'b0;
    in_chan.pid = '0;
    out_chan.ready = 1'b0;
    for (int i = 0; i < SLOTS*PAGES; i++) begin
      pg_valid[i] = 0; pg_writable[i] = 0; pg_private[i] = 0; pg_frame[i] = 0;
    end
    for (int f = 0; f < FRAMES; f++) frame_refs[f] = 0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_busy[s] = (s == 0); slot_owner[s] = 0;
    end
    cur_slot = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_alloc_free_edges();
    test_fork_and_cow();
    test_frame_exhaustion();
    test_random_actions(1100);
    in_chan.valid <= 1'b0;

    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (errors == 0 && expected_outcomes.size() == 0)
      $display("cow_page_frame_manager_tb OK");
    else
      $display("cow_page_frame_manager_tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/cpfm_pkg.sv
rtl/core/cpfm_if.sv
rtl/core/cpfm_ram.sv
rtl/core/cow_page_frame_manager.sv
test/cow_page_frame_manager_tb.sv
